@@ src/pse_pkg.sv @@
// Shared types, codes and the microcode ROM of the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int DEPTH_OUT_W = 7;
    localparam int UA_W        = 4;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_FINISH = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_FEW     = 2'd2,
        ST_DIVZERO = 2'd3
    } t_status;

    // jump conditions
    typedef enum logic [2:0] {
        C_NONE   = 3'd0,
        C_ALWAYS = 3'd1,
        C_FULL   = 3'd2,
        C_FEW    = 3'd3,
        C_EMPTY  = 3'd4,
        C_ISDIV  = 3'd5,
        C_DIVZ   = 3'd6,
        C_DBUSY  = 3'd7
    } t_cond;

    // datapath actions
    typedef enum logic [3:0] {
        A_NOP    = 4'd0,
        A_PUSH   = 4'd1,
        A_RDLHS  = 4'd2,
        A_LDLHS  = 4'd3,
        A_ALU    = 4'd4,
        A_COMMIT = 4'd5,
        A_DSTART = 4'd6,
        A_DLOAD  = 4'd7,
        A_CLEAR  = 4'd8
    } t_act;

    typedef struct packed {
        t_cond             cond;
        logic [UA_W-1:0]   target;
        t_act              act;
        logic              emit;
        t_status           status;
        logic              is_last;
    } t_uword;

    typedef struct packed {
        logic full;
        logic few;
        logic empty;
        logic is_div;
        logic div_zero;
        logic div_busy;
    } t_flags;

    typedef struct packed {
        t_act    act;
        logic    emit;
        t_status status;
        logic    is_last;
    } t_ctl;

    // microcode addresses
    localparam logic [UA_W-1:0] UA_PUSH   = 4'd0;
    localparam logic [UA_W-1:0] UA_BIN    = 4'd1;
    localparam logic [UA_W-1:0] UA_LDLHS  = 4'd2;
    localparam logic [UA_W-1:0] UA_ALU    = 4'd3;
    localparam logic [UA_W-1:0] UA_COMMIT = 4'd4;
    localparam logic [UA_W-1:0] UA_DIV    = 4'd5;
    localparam logic [UA_W-1:0] UA_DWAIT  = 4'd6;
    localparam logic [UA_W-1:0] UA_DBACK  = 4'd7;
    localparam logic [UA_W-1:0] UA_FINISH = 4'd8;
    localparam logic [UA_W-1:0] UA_EFULL  = 4'd9;
    localparam logic [UA_W-1:0] UA_EFEW   = 4'd10;
    localparam logic [UA_W-1:0] UA_EDZ    = 4'd11;
    localparam logic [UA_W-1:0] UA_EFEWF  = 4'd12;
    localparam logic [UA_W-1:0] UA_IGNORE = 4'd13;

    function automatic t_uword mk(input t_cond c, input logic [UA_W-1:0] t, input t_act a,
                                  input logic e, input t_status s, input logic l);
        t_uword w;
        w.cond    = c;
        w.target  = t;
        w.act     = a;
        w.emit    = e;
        w.status  = s;
        w.is_last = l;
        return w;
    endfunction

    // When the condition holds the word jumps and does nothing else;
    // otherwise it runs its action, then emits or falls through.
    function automatic t_uword ucode(input logic [UA_W-1:0] a);
        t_uword w;
        unique case (a)
            UA_PUSH:   w = mk(C_FULL,   UA_EFULL,  A_PUSH,   1'b1, ST_OK,      1'b0);
            UA_BIN:    w = mk(C_FEW,    UA_EFEW,   A_RDLHS,  1'b0, ST_OK,      1'b0);
            UA_LDLHS:  w = mk(C_NONE,   UA_PUSH,   A_LDLHS,  1'b0, ST_OK,      1'b0);
            UA_ALU:    w = mk(C_ISDIV,  UA_DIV,    A_ALU,    1'b0, ST_OK,      1'b0);
            UA_COMMIT: w = mk(C_NONE,   UA_PUSH,   A_COMMIT, 1'b1, ST_OK,      1'b0);
            UA_DIV:    w = mk(C_DIVZ,   UA_EDZ,    A_DSTART, 1'b0, ST_OK,      1'b0);
            UA_DWAIT:  w = mk(C_DBUSY,  UA_DWAIT,  A_DLOAD,  1'b0, ST_OK,      1'b0);
            UA_DBACK:  w = mk(C_ALWAYS, UA_COMMIT, A_NOP,    1'b0, ST_OK,      1'b0);
            UA_FINISH: w = mk(C_EMPTY,  UA_EFEWF,  A_CLEAR,  1'b1, ST_OK,      1'b1);
            UA_EFULL:  w = mk(C_NONE,   UA_PUSH,   A_NOP,    1'b1, ST_FULL,    1'b0);
            UA_EFEW:   w = mk(C_NONE,   UA_PUSH,   A_NOP,    1'b1, ST_FEW,     1'b0);
            UA_EDZ:    w = mk(C_NONE,   UA_PUSH,   A_NOP,    1'b1, ST_DIVZERO, 1'b0);
            UA_EFEWF:  w = mk(C_NONE,   UA_PUSH,   A_NOP,    1'b1, ST_FEW,     1'b1);
            default:   w = mk(C_NONE,   UA_PUSH,   A_NOP,    1'b1, ST_OK,      1'b0);
        endcase
        return w;
    endfunction

    function automatic logic [UA_W-1:0] entry_addr(input logic [OP_W-1:0] op);
        logic [UA_W-1:0] a;
        unique case (op) inside
            OP_PUSH:                        a = UA_PUSH;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: a = UA_BIN;
            OP_FINISH:                      a = UA_FINISH;
            default:                        a = UA_IGNORE;
        endcase
        return a;
    endfunction

endpackage

@@ src/pse_tok_if.sv @@
// Token channel: operation and value with valid/ready.
`timescale 1ns / 1ps
interface pse_tok_if;
    import pse_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ src/pse_res_if.sv @@
// Result channel: top value, depth, status and final flag with valid/ready.
`timescale 1ns / 1ps
interface pse_res_if;
    import pse_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_OUT_W-1:0]   depth_now;
    logic [1:0]               status;
    logic                     is_final;

    modport source (output valid, output top_value, output depth_now, output status,
                    output is_final, input ready);
    modport sink   (input valid, input top_value, input depth_now, input status,
                    input is_final, output ready);
endinterface

@@ src/pse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ src/pse_divider.sv @@
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module pse_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [pse_pkg::DATA_W-1:0] i_dividend,
    input  logic signed [pse_pkg::DATA_W-1:0] i_divisor,
    output logic                              o_busy,
    output logic [pse_pkg::DATA_W-1:0]        o_quotient
);
    import pse_pkg::*;

    localparam int CW = $clog2(DATA_W + 1);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   trial;

    assign rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DATA_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? -i_dividend : i_dividend;
            r_dvs <= i_divisor[DATA_W-1] ? -i_divisor : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!trial[DATA_W]) begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    // most negative / -1 wraps back to the most negative value here
    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -r_quo : r_quo;
endmodule

@@ src/pse_sequencer.sv @@
// Microcode sequencer: step counter, ROM fetch, condition test and jumps.
`timescale 1ns / 1ps
module pse_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pse_pkg::OP_W-1:0]   i_op,
    input  pse_pkg::t_flags            i_flags,
    input  logic                       i_out_free,
    output logic                       o_busy,
    output pse_pkg::t_ctl              o_ctl
);
    import pse_pkg::*;

    logic            r_busy;
    logic [UA_W-1:0] r_upc;
    t_uword          w;
    logic            cond_true;
    logic            stall;
    logic            exec;

    assign w = ucode(r_upc);

    always_comb begin
        unique case (w.cond)
            C_NONE:   cond_true = 1'b0;
            C_ALWAYS: cond_true = 1'b1;
            C_FULL:   cond_true = i_flags.full;
            C_FEW:    cond_true = i_flags.few;
            C_EMPTY:  cond_true = i_flags.empty;
            C_ISDIV:  cond_true = i_flags.is_div;
            C_DIVZ:   cond_true = i_flags.div_zero;
            C_DBUSY:  cond_true = i_flags.div_busy;
            default:  cond_true = 1'b0;
        endcase
    end

    // an emitting word waits for the output register to free up
    assign stall = w.emit && !i_out_free;
    assign exec  = r_busy && !cond_true && !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= UA_PUSH;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_upc  <= entry_addr(i_op);
            end
        end else if (cond_true) begin
            r_upc <= w.target;
        end else if (!stall) begin
            if (w.emit) begin
                r_busy <= 1'b0;
            end else begin
                r_upc <= r_upc + UA_W'(1);
            end
        end
    end

    assign o_busy        = r_busy;
    assign o_ctl.act     = exec ? w.act : A_NOP;
    assign o_ctl.emit    = exec && w.emit;
    assign o_ctl.status  = w.status;
    assign o_ctl.is_last = w.is_last;
endmodule

@@ src/postfix_stack_evaluator.sv @@
// Top level: postfix evaluator datapath around the microcode sequencer.
//
//   channel | dir | word fields
//   --------+-----+--------------------------------------------
//   i_tok   | in  | operation[2:0], value[31:0] signed
//   o_res   | out | top_value[31:0] signed, depth_now[6:0],
//           |     | status[1:0], is_final
//
// Push, finish and unused codes run one microcode word; add, subtract and
// multiply run read, load, ALU and commit words; divide adds start, wait
// and load words for the 32-step restoring divider. Errors jump to a word
// that emits the status. Operators pay one stack RAM read for the left operand.
// Sync active-low reset empties the stack; the RAM contents stay undefined.
// A result held in o_res stalls only the step that would emit the next one.
`timescale 1ns / 1ps
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pse_tok_if.sink   i_tok,
    pse_res_if.source o_res
);
    import pse_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic [SPW-1:0]    r_sp,  n_sp;
    logic [DATA_W-1:0] r_top, n_top;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_lhs;
    logic [DATA_W-1:0] r_res;

    logic                   r_ovalid;
    logic [DATA_W-1:0]      r_o_top;
    logic [DEPTH_OUT_W-1:0] r_o_depth;
    t_status                r_o_status;
    logic                   r_o_final;

    logic              busy;
    logic              accept;
    logic              out_free;
    t_flags            flags;
    t_ctl              ctl;
    logic              div_busy;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] rd_data;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     lhs_addr;
    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W-1:0] rep_top;

    assign i_tok.ready = !busy;
    assign accept      = i_tok.valid && !busy;
    assign out_free    = !r_ovalid || o_res.ready;

    assign flags.full     = r_sp >= SPW'(STACK_DEPTH);
    assign flags.few      = r_sp < SPW'(2);
    assign flags.empty    = r_sp == '0;
    assign flags.is_div   = r_op == OP_DIV;
    assign flags.div_zero = r_top == '0;
    assign flags.div_busy = div_busy;

    pse_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_op       (i_tok.operation),
        .i_flags    (flags),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    assign lhs_addr  = AW'(r_sp - SPW'(2));
    assign ram_we    = (ctl.act == A_PUSH) || (ctl.act == A_COMMIT);
    assign ram_waddr = (ctl.act == A_PUSH) ? AW'(r_sp) : lhs_addr;
    assign ram_wdata = (ctl.act == A_PUSH) ? r_val : r_res;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ctl.act == A_RDLHS),
        .i_rd_addr (lhs_addr),
        .o_rd_data (rd_data)
    );

    pse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.act == A_DSTART),
        .i_dividend (r_lhs),
        .i_divisor  (r_top),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign mul_lo = r_lhs * r_top;

    // r_top caches the entry at sp-1; the RAM holds every entry as well
    always_comb begin
        n_sp  = r_sp;
        n_top = r_top;
        case (ctl.act)
            A_PUSH: begin
                n_sp  = r_sp + SPW'(1);
                n_top = r_val;
            end
            A_COMMIT: begin
                n_sp  = r_sp - SPW'(1);
                n_top = r_res;
            end
            A_CLEAR: n_sp = '0;
            default: ;
        endcase
    end

    // finish reports the top as it stood before clearing
    always_comb begin
        if (ctl.is_last) begin
            rep_top = (r_sp == '0) ? '0 : r_top;
        end else begin
            rep_top = (n_sp == '0) ? '0 : n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_sp <= n_sp;
            if (ctl.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (accept) begin
            r_op  <= i_tok.operation;
            r_val <= i_tok.value;
        end
        if (ctl.act == A_LDLHS) begin
            r_lhs <= rd_data;
        end
        if (ctl.act == A_ALU) begin
            case (r_op)
                OP_ADD:  r_res <= r_lhs + r_top;
                OP_SUB:  r_res <= r_lhs - r_top;
                default: r_res <= mul_lo;
            endcase
        end else if (ctl.act == A_DLOAD) begin
            r_res <= div_quo;
        end
        if (ctl.emit) begin
            r_o_top    <= rep_top;
            r_o_depth  <= DEPTH_OUT_W'(n_sp);
            r_o_status <= ctl.status;
            r_o_final  <= ctl.is_last;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.top_value = r_o_top;
    assign o_res.depth_now = r_o_depth;
    assign o_res.status    = r_o_status;
    assign o_res.is_final  = r_o_final;
endmodule

@@ test/postfix_result_checker.sv @@
// Scoreboard for the postfix evaluator: mirrors the operand stack and checks every result word.
`timescale 1ns / 1ps
module postfix_result_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pse_tok_if   i_tok,
    pse_res_if   i_res,
    output int   o_mismatches,
    output int   o_pending
);
    import pse_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_OUT_W-1:0]   depth_now;
        t_status                  status;
        logic                     is_final;
    } t_stack_result;

    t_stack_result     expected_results[$];
    logic [DATA_W-1:0] operand_stack[STACK_DEPTH];
    int                stack_ptr;

    function automatic t_stack_result evaluate_token(input logic [OP_W-1:0] op,
                                                     input logic [DATA_W-1:0] value);
        t_stack_result     r;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        longint            quotient;
        r.status   = ST_OK;
        r.is_final = 1'b0;
        res        = '0;
        case (op) inside
            OP_PUSH: begin
                if (stack_ptr >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    operand_stack[stack_ptr] = value;
                    stack_ptr++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (stack_ptr < 2) begin
                    r.status = ST_FEW;
                end else begin
                    rhs = operand_stack[stack_ptr-1];
                    lhs = operand_stack[stack_ptr-2];
                    case (op)
                        OP_ADD:  res = lhs + rhs;
                        OP_SUB:  res = lhs - rhs;
                        OP_MUL:  res = lhs * rhs;
                        default: begin
                            // 64-bit divide so min / -1 wraps instead of trapping
                            if (rhs == '0) begin
                                r.status = ST_DIVZERO;
                            end else begin
                                quotient = longint'($signed(lhs)) / longint'($signed(rhs));
                                res      = quotient[DATA_W-1:0];
                            end
                        end
                    endcase
                    if (r.status == ST_OK) begin
                        stack_ptr--;
                        operand_stack[stack_ptr-1] = res;
                    end
                end
            end
            OP_FINISH: begin
                r.is_final = 1'b1;
                if (stack_ptr == 0) begin
                    r.status    = ST_FEW;
                    r.top_value = '0;
                end else begin
                    r.top_value = operand_stack[stack_ptr-1];
                end
                stack_ptr = 0;
            end
            default: ;  // spare codes leave the stack alone
        endcase
        if (op != OP_FINISH) begin
            r.top_value = (stack_ptr == 0) ? '0 : operand_stack[stack_ptr-1];
        end
        r.depth_now = stack_ptr[DEPTH_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            stack_ptr = 0;
            expected_results.delete();
            o_mismatches = 0;
        end else begin
            // result first: a token taken on this edge cannot answer on the same edge
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no token outstanding: top_value %0d",
                           i_res.top_value);
                    o_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.top_value !== want.top_value) begin
                        $error("top_value: expected %0d, got %0d",
                               want.top_value, i_res.top_value);
                        o_mismatches++;
                    end
                    if (i_res.depth_now !== want.depth_now) begin
                        $error("depth_now: expected %0d, got %0d",
                               want.depth_now, i_res.depth_now);
                        o_mismatches++;
                    end
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        o_mismatches++;
                    end
                    if (i_res.is_final !== want.is_final) begin
                        $error("is_final: expected %0d, got %0d",
                               want.is_final, i_res.is_final);
                        o_mismatches++;
                    end
                end
            end
            if (i_tok.valid && i_tok.ready) begin
                expected_results.push_back(evaluate_token(i_tok.operation, i_tok.value));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ test/postfix_stack_evaluator_test.sv @@
// Testbench top for the postfix evaluator: token stimulus, result drain, watchdog and verdict.
`timescale 1ns / 1ps
module postfix_stack_evaluator_test;
    import pse_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int ITEM_TARGET  = 1675;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_NEG1    = 32'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    int   tokens_sent;
    bit   quiet_tail;
    bit   hold_done;
    int   mismatches;
    int   pending;
    int   stall_cycles;

    pse_tok_if tok_ch ();
    pse_res_if res_ch ();

    postfix_stack_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_ch),
        .o_res   (res_ch)
    );

    postfix_result_checker #(.STACK_DEPTH(STACK_DEPTH)) checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok        (tok_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9)) inside
            0:       v = '0;
            1:       v = 32'd1;
            2:       v = VAL_NEG1;
            3:       v = VAL_MAX;
            4:       v = VAL_MIN;
            5, 6:    v = DATA_W'($urandom_range(0, 200)) - 32'd100;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [OP_W-1:0] pick_operator();
        logic [OP_W-1:0] op;
        case ($urandom_range(0, 3))
            0:       op = OP_ADD;
            1:       op = OP_SUB;
            2:       op = OP_MUL;
            default: op = OP_DIV;
        endcase
        return op;
    endfunction

    // one word on the token channel; valid stays up across back-to-back words
    task automatic send_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            tok_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        tok_ch.valid     <= 1'b1;
        tok_ch.operation <= op;
        tok_ch.value     <= value;
        do @(posedge i_clk); while (!tok_ch.ready);
        tokens_sent++;
    endtask

    // well-formed postfix expression ending in a finish
    task automatic send_expression(input int operand_count);
        int depth;
        int pushed;
        depth  = 0;
        pushed = 0;
        while (pushed < operand_count || depth > 1) begin
            if (depth >= 2 && (pushed == operand_count || $urandom_range(0, 2) == 0)) begin
                send_token(pick_operator(), $urandom);
                depth--;
            end else begin
                send_token(OP_PUSH, pick_operand());
                depth++;
                pushed++;
            end
        end
        send_token(OP_FINISH, $urandom);
    endtask

    // runs past the top of the stack so pushes bounce off a full stack
    task automatic send_overfill();
        repeat (STACK_DEPTH + $urandom_range(1, 4)) send_token(OP_PUSH, pick_operand());
        repeat ($urandom_range(0, 6)) send_token(pick_operator(), $urandom);
        send_token(OP_FINISH, $urandom);
    endtask

    initial begin
        int pick;
        tok_ch.valid     = 1'b0;
        tok_ch.operation = OP_PUSH;
        tok_ch.value     = '0;
        tokens_sent      = 0;
        quiet_tail       = 1'b0;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner cases on a known stack
        send_token(OP_FINISH, $urandom);     // finish on empty
        send_token(OP_ADD, $urandom);        // operator on empty
        send_token(OP_SPARE_LO, $urandom);
        send_token(OP_PUSH, VAL_MAX);
        send_token(OP_DIV, $urandom);        // one operand only
        send_token(OP_PUSH, 32'd1);
        send_token(OP_ADD, $urandom);        // max + 1 wraps to min
        send_token(OP_PUSH, VAL_NEG1);
        send_token(OP_DIV, $urandom);        // min / -1 wraps
        send_token(OP_PUSH, '0);
        send_token(OP_DIV, $urandom);        // divide by zero, stack kept
        send_token(OP_SUB, $urandom);
        send_token(OP_PUSH, 32'd2);
        send_token(OP_MUL, $urandom);        // min * 2 wraps to 0
        send_token(OP_SPARE_HI, $urandom);
        send_token(OP_PUSH, -32'sd7);
        send_token(OP_PUSH, 32'd2);
        send_token(OP_DIV, $urandom);        // truncates toward zero
        send_token(OP_PUSH, 32'd7);
        send_token(OP_PUSH, -32'sd2);
        send_token(OP_DIV, $urandom);
        send_token(OP_MUL, $urandom);
        send_token(OP_SUB, $urandom);
        send_token(OP_FINISH, $urandom);

        send_overfill();
        while (tokens_sent < ITEM_TARGET) begin
            if (tokens_sent >= ITEM_TARGET - TAIL_ITEMS) quiet_tail = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_overfill();
            end else if (pick < 80) begin
                send_expression($urandom_range(1, 8));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 5))
                    send_token(OP_W'($urandom_range(0, (1 << OP_W) - 1)), $urandom);
            end else begin
                // truncated expression: push, operator (short of operands if the push was the only entry), then finish
                send_token(OP_PUSH, pick_operand());
                send_token(pick_operator(), $urandom);
                send_token(OP_FINISH, $urandom);
            end
        end
        @(negedge i_clk);
        tok_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result sink: random back-pressure plus one long hold-off to fill the block
    initial begin
        res_ch.ready = 1'b0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && tokens_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    // cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
src/pse_pkg.sv
src/pse_tok_if.sv
src/pse_res_if.sv
src/pse_ram.sv
src/pse_divider.sv
src/pse_sequencer.sv
src/postfix_stack_evaluator.sv
test/postfix_result_checker.sv
test/postfix_stack_evaluator_test.sv
